// File: hw/rtl/cifp_pkg.sv
// cifp_pkg: shared types, codes and constants of the image header stream parser
// used by every module under hw/rtl; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package cifp_pkg;

   // bytes per little-endian size field, 1 to 8
   localparam int FIELD_BYTES = 8;
   localparam logic [2:0] FIELD_LAST = 3'((FIELD_BYTES - 1) % 8);

   localparam int MAGIC_BYTES = 4;
   localparam logic [7:0] MAGIC_WORD [MAGIC_BYTES] = '{8'h43, 8'h49, 8'h46, 8'h46};
   localparam logic [1:0] MAGIC_LAST = 2'(MAGIC_BYTES - 1);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [9:0] PIXEL_BYTES = 10'd3;

   typedef enum logic [3:0] {
      PH_MAGIC   = 4'd0,
      PH_HDR     = 4'd1,
      PH_CONT    = 4'd2,
      PH_WID     = 4'd3,
      PH_HGT     = 4'd4,
      PH_CAPTION = 4'd5,
      PH_TAGS    = 4'd6,
      PH_PIXELS  = 4'd7,
      PH_DONE    = 4'd8,
      PH_ERROR   = 4'd9
   } phase_type;

   typedef enum logic [3:0] {
      CL_MAGIC       = 4'd0,
      CL_HDR_SIZE    = 4'd1,
      CL_CONT_SIZE   = 4'd2,
      CL_WIDTH       = 4'd3,
      CL_HEIGHT      = 4'd4,
      CL_CAPTION     = 4'd5,
      CL_CAPTION_END = 4'd6,
      CL_TAG         = 4'd7,
      CL_TAG_END     = 4'd8,
      CL_PIXEL       = 4'd9,
      CL_TRAILING    = 4'd10
   } class_type;

   typedef enum logic [2:0] {
      ST_BUSY      = 3'd0,
      ST_COMPLETE  = 3'd1,
      ST_BAD_MAGIC = 3'd2,
      ST_MISMATCH  = 3'd3,
      ST_OVERRUN   = 3'd4,
      ST_TRUNCATED = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } beat_type;

   typedef struct packed {
      class_type          byte_class;
      logic [7:0]         byte_out;
      status_type         status;
      logic signed [63:0] image_width;
      logic signed [63:0] image_height;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/ciff_header_stream_parser.sv
// ciff_header_stream_parser: top level of the image header stream parser
// depends on cifp_pkg, cifp_in_stage, cifp_parse_core, cifp_out_stage
`timescale 1ns / 1ps
`default_nettype none

// Parses an image file streamed one byte per beat and returns one result beat
// per input byte: the byte's class, the byte itself and the running status,
// along with the decoded width and height. The file must open with the magic
// "CIFF", then four little-endian size fields (header size, content size,
// width, height); 3*width*height must equal the content size (64-bit wrap).
// Caption bytes run to a newline, zero-terminated tags run until the position
// after a tag end equals the header size, then exactly content-size pixel bytes
// follow. Bytes after completion or after an error come back as trailing with
// the final status. A beat flagged last returns the parser to its start state,
// so files can be sent back to back. Throughput is one byte per clock while
// the receiver does not stall; each byte is held in the input register and
// its result beat in the result register until taken. The state update (64-bit
// position compare and the 64x8 multiply-accumulate that builds the size check
// while the height arrives) sets the clock period.
module ciff_header_stream_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   // input beats
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_last_byte,
   // result beats
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_byte_class,
   output logic [7:0]              rsp_byte_out,
   output logic [2:0]              rsp_status,
   output logic signed [63:0]      rsp_image_width,
   output logic signed [63:0]      rsp_image_height
);
   import cifp_pkg::*;

   logic       out_take;     // result register can take a beat this cycle
   logic       beat_valid;   // input register holds a beat
   logic       fire;         // beat moves through the parser this cycle
   beat_type   beat;
   result_type result;
   result_type rsp_result;

   assign fire = beat_valid & out_take;

   // input register
   cifp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .out_take      (out_take),
      .beat_valid    (beat_valid),
      .beat          (beat)
   );

   // parse state and classification, updated once per moving beat
   cifp_parse_core u_parse_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .beat   (beat),
      .result (result)
   );

   // result register, decouples the two sides
   cifp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .out_take   (out_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_byte_class   = rsp_result.byte_class;
   assign rsp_byte_out     = rsp_result.byte_out;
   assign rsp_status       = rsp_result.status;
   assign rsp_image_width  = rsp_result.image_width;
   assign rsp_image_height = rsp_result.image_height;

endmodule

`default_nettype wire

// File: hw/rtl/cifp_in_stage.sv
// cifp_in_stage: input register of the parser, takes one byte beat per cycle unless stalled
// depends on cifp_pkg
`timescale 1ns / 1ps
`default_nettype none

module cifp_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_last_byte,
   output logic                   req_stall,
   input  wire logic              out_take,
   output logic                   beat_valid,
   output cifp_pkg::beat_type     beat
);
   import cifp_pkg::*;

   logic     valid_ff;
   beat_type beat_ff;

   // hold only while a beat sits here and the result side cannot move
   assign req_stall = valid_ff & ~out_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         beat_ff.data_byte <= req_data_byte;
         beat_ff.last_byte <= req_last_byte;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cifp_parse_core.sv
// cifp_parse_core: parse state, field assembly and per-byte classification
// depends on cifp_pkg
`timescale 1ns / 1ps
`default_nettype none

module cifp_parse_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire cifp_pkg::beat_type beat,
   output cifp_pkg::result_type   result
);
   import cifp_pkg::*;

   phase_type   phase_ff, phase_in;
   status_type  err_ff, err_in, err_now;
   logic [63:0] next_pos_ff, next_pos_in;   // position after the current byte
   logic [2:0]  count_ff, count_in;
   logic [63:0] hdr_len_ff, hdr_len_in;
   logic [63:0] pay_len_ff, pay_len_in;
   logic [63:0] width_ff, width_in;
   logic [63:0] height_ff, height_in;
   logic [63:0] width3_ff, width3_in;       // 3 * width, built with the width
   logic [63:0] prod_ff, prod_in;           // 3 * width * height so far
   logic [63:0] pixels_ff, pixels_in;

   logic [5:0]  shift;
   logic [63:0] byte_wide;
   logic [63:0] term3;
   logic [63:0] mult_full;
   logic [63:0] prod_sum;
   logic        field_end;
   logic        hdr_hit;
   logic        hdr_past;
   logic        size_ok;
   class_type   cls;
   status_type  st;

   assign shift     = {count_ff, 3'b000};
   assign byte_wide = 64'(beat.data_byte) << shift;
   assign term3     = 64'(10'(beat.data_byte) * PIXEL_BYTES) << shift;
   assign mult_full = width3_ff * 64'(beat.data_byte);
   assign prod_sum  = prod_ff + (mult_full << shift);
   assign size_ok   = (prod_sum == pay_len_ff);
   assign field_end = (count_ff >= FIELD_LAST);
   assign hdr_hit   = (next_pos_ff == hdr_len_ff);
   assign hdr_past  = (next_pos_ff > hdr_len_ff);
   assign next_pos_in = next_pos_ff + 64'd1;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      err_now   = ST_BUSY;
      err_in    = err_ff;
      count_in  = count_ff;
      hdr_len_in = hdr_len_ff;
      pay_len_in = pay_len_ff;
      width_in  = width_ff;
      height_in = height_ff;
      width3_in = width3_ff;
      prod_in   = prod_ff;
      pixels_in = pixels_ff;
      case (phase_ff)
         PH_MAGIC: begin
            if (beat.data_byte != MAGIC_WORD[count_ff[1:0]]) begin
               err_now = ST_BAD_MAGIC;
            end else if (count_ff[1:0] >= MAGIC_LAST) begin
               count_in = 3'd0;
               phase_in = PH_HDR;
            end else begin
               count_in = 3'(count_ff + 3'd1);
            end
         end
         PH_HDR, PH_CONT, PH_WID, PH_HGT: begin
            case (phase_ff)
               PH_HDR:  hdr_len_in = hdr_len_ff | byte_wide;
               PH_CONT: pay_len_in = pay_len_ff | byte_wide;
               PH_WID: begin
                  width_in  = width_ff | byte_wide;
                  width3_in = width3_ff + term3;
               end
               default: begin
                  height_in = height_ff | byte_wide;
                  prod_in   = prod_sum;
               end
            endcase
            if (field_end) begin
               count_in = 3'd0;
               case (phase_ff)
                  PH_HDR:  phase_in = PH_CONT;
                  PH_CONT: phase_in = PH_WID;
                  PH_WID:  phase_in = PH_HGT;
                  default: begin
                     if (size_ok) begin
                        phase_in = PH_CAPTION;
                     end else begin
                        err_now = ST_MISMATCH;
                     end
                  end
               endcase
            end else begin
               count_in = 3'(count_ff + 3'd1);
            end
         end
         PH_CAPTION, PH_TAGS: begin
            if (phase_ff == PH_CAPTION && beat.data_byte == CHAR_NEWLINE && !hdr_hit) begin
               phase_in = PH_TAGS;
            end else if ((phase_ff == PH_CAPTION && beat.data_byte == CHAR_NEWLINE)
                         || (phase_ff == PH_TAGS && beat.data_byte == CHAR_NUL && hdr_hit)) begin
               // header ends here: content follows unless it is empty
               if (pay_len_ff == 64'd0) begin
                  phase_in = PH_DONE;
               end else begin
                  pixels_in = pay_len_ff;
                  phase_in  = PH_PIXELS;
               end
            end else if (phase_ff == PH_TAGS && beat.data_byte == CHAR_NUL && hdr_past) begin
               err_now = ST_OVERRUN;
            end
         end
         PH_PIXELS: begin
            pixels_in = pixels_ff - 64'd1;
            if (pixels_ff == 64'd1) begin
               phase_in = PH_DONE;
            end
         end
         default: begin
         end
      endcase
      if (err_now != ST_BUSY) begin
         phase_in = PH_ERROR;
         err_in   = err_now;
      end
   end

   // outputs
   always_comb begin
      case (phase_ff)
         PH_MAGIC:   cls = CL_MAGIC;
         PH_HDR:     cls = CL_HDR_SIZE;
         PH_CONT:    cls = CL_CONT_SIZE;
         PH_WID:     cls = CL_WIDTH;
         PH_HGT:     cls = CL_HEIGHT;
         PH_CAPTION: cls = (beat.data_byte == CHAR_NEWLINE) ? CL_CAPTION_END : CL_CAPTION;
         PH_TAGS:    cls = (beat.data_byte == CHAR_NUL) ? CL_TAG_END : CL_TAG;
         PH_PIXELS:  cls = CL_PIXEL;
         default:    cls = CL_TRAILING;
      endcase
      if (phase_in == PH_ERROR) begin
         st = err_in;
      end else if (phase_in == PH_DONE) begin
         st = ST_COMPLETE;
      end else if (beat.last_byte) begin
         st = ST_TRUNCATED;
      end else begin
         st = ST_BUSY;
      end
      result.byte_class   = cls;
      result.byte_out     = beat.data_byte;
      result.status       = st;
      result.image_width  = width_in;
      result.image_height = height_in;
   end

   // a final byte sends everything back to the start of the next file
   always_ff @(posedge clock) begin
      if (reset || (fire && beat.last_byte)) begin
         phase_ff    <= PH_MAGIC;
         err_ff      <= ST_BUSY;
         next_pos_ff <= 64'd1;
         count_ff    <= 3'd0;
         hdr_len_ff  <= 64'd0;
         pay_len_ff  <= 64'd0;
         width_ff    <= 64'd0;
         height_ff   <= 64'd0;
         width3_ff   <= 64'd0;
         prod_ff     <= 64'd0;
         pixels_ff   <= 64'd0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         err_ff      <= err_in;
         next_pos_ff <= next_pos_in;
         count_ff    <= count_in;
         hdr_len_ff  <= hdr_len_in;
         pay_len_ff  <= pay_len_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         width3_ff   <= width3_in;
         prod_ff     <= prod_in;
         pixels_ff   <= pixels_in;
      end
   end

`ifndef SYNTH
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_ERROR |-> result.status == err_ff
                                       && result.byte_class == CL_TRAILING)
      else $error("error phase did not report latched status");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |-> err_ff == ST_BAD_MAGIC || err_ff == ST_MISMATCH
                               || err_ff == ST_OVERRUN)
      else $error("error phase without an error code");

   a_pixels_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIXELS |-> pixels_ff != 64'd0)
      else $error("pixel phase with no pixels left");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      fire && beat.last_byte |=> phase_ff == PH_MAGIC && next_pos_ff == 64'd1
                                  && count_ff == 3'd0)
      else $error("final byte did not restart the parse");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/cifp_out_stage.sv
// cifp_out_stage: result register of the parser, holds a beat until taken
// depends on cifp_pkg
`timescale 1ns / 1ps
`default_nettype none

module cifp_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire cifp_pkg::result_type result,
   output logic                      out_take,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output cifp_pkg::result_type      rsp_result
);
   import cifp_pkg::*;

   logic       valid_ff;
   result_type result_ff;

   // the register can load when empty or when its beat leaves now
   assign out_take = ~valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_take) begin
         valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

// File: test/ciff_header_stream_parser_tb.sv
`timescale 1ns / 1ps
// ciff_header_stream_parser_tb: self-checking bench for the image header stream parser
// depends on cifp_pkg and ciff_header_stream_parser, nothing else

module ciff_header_stream_parser_tb;
   import cifp_pkg::*;

   // stop adding files once this many bytes are queued
   localparam int TARGET_BEATS = 850;
   // receiver hold-off long enough to back the parser up into its input
   localparam int LONG_HOLD = 300;
   // settle time after the last result, past the input and result registers
   localparam int DRAIN_CYCLES = 8;
   // content sizes above this are sent short; only mismatch files have them, so these end in an error
   localparam int MAX_PIXELS = 18;
   localparam longint LIMIT_NS = 2_000_000;
   localparam int MAX_REPORTS = 50;

   typedef struct {
      logic [7:0] data;
      logic       fin;
      bit         wait_drain;  // sender waits for every result before this beat
      bit         hold_rsp;    // receiver starts a long hold-off when this beat goes out
   } file_beat_type;

   typedef enum int {
      FK_TAGGED, FK_PLAIN, FK_EMPTY, FK_ALL_ONES, FK_TRUNC,
      FK_MISMATCH, FK_OVERRUN, FK_HUGE_HDR, FK_BAD_MAGIC, FK_NOISE
   } file_kind_type;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [3:0]         rsp_byte_class;
   logic [7:0]         rsp_byte_out;
   logic [2:0]         rsp_status;
   logic signed [63:0] rsp_image_width;
   logic signed [63:0] rsp_image_height;

   ciff_header_stream_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_class   (rsp_byte_class),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_status       (rsp_status),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // parser mirror: tracks the file position and the decoded fields
   // ---------------------------------------------------------------
   phase_type   ph;
   logic [63:0] byte_pos;
   logic [2:0]  fcnt;
   logic [5:0]  fshift;
   logic [63:0] hdr_len;
   logic [63:0] cont_len;
   logic [63:0] wid_val;
   logic [63:0] hgt_val;
   logic [63:0] pix_left;
   status_type  err_latched;

   // per-file outcomes, for the summary
   int unsigned files_complete = 0;
   int unsigned files_failed = 0;
   int unsigned files_cut = 0;

   function automatic void clear_parser();
      ph = PH_MAGIC;
      byte_pos = '0;
      fcnt = '0;
      fshift = '0;
      hdr_len = '0;
      cont_len = '0;
      wid_val = '0;
      hgt_val = '0;
      pix_left = '0;
      err_latched = ST_BUSY;
   endfunction

   // header ends: either straight to done (no content) or into the pixel run
   function automatic void start_pixels();
      if (cont_len == 0) begin
         ph = PH_DONE;
      end else begin
         pix_left = cont_len;
         ph = PH_PIXELS;
      end
   endfunction

   function automatic result_type classify_byte(input logic [7:0] b, input logic fin);
      result_type res;
      logic [63:0] next_pos;
      class_type   cls;
      status_type  err;
      status_type  st;
      next_pos = byte_pos + 64'd1;
      cls = CL_TRAILING;
      err = ST_BUSY;
      case (ph)
         PH_MAGIC: begin
            // a wrong magic byte is flagged on the spot
            cls = CL_MAGIC;
            if (b != MAGIC_WORD[fcnt[1:0]]) begin
               err = ST_BAD_MAGIC;
            end else if (fcnt >= MAGIC_LAST) begin
               fcnt = '0;
               fshift = '0;
               ph = PH_HDR;
            end else begin
               fcnt = fcnt + 3'd1;
            end
         end
         PH_HDR, PH_CONT, PH_WID, PH_HGT: begin
            cls = class_type'(ph);
            case (ph)
               PH_HDR:  hdr_len = hdr_len | (64'(b) << fshift);
               PH_CONT: cont_len = cont_len | (64'(b) << fshift);
               PH_WID:  wid_val = wid_val | (64'(b) << fshift);
               default: hgt_val = hgt_val | (64'(b) << fshift);
            endcase
            if (fcnt >= FIELD_LAST) begin
               fcnt = '0;
               fshift = '0;
               if (ph == PH_HGT) begin
                  // size check wraps at 64 bits
                  if (wid_val * hgt_val * 64'(PIXEL_BYTES) != cont_len) begin
                     err = ST_MISMATCH;
                  end else begin
                     ph = PH_CAPTION;
                  end
               end else begin
                  ph = phase_type'(ph + 4'd1);
               end
            end else begin
               fcnt = fcnt + 3'd1;
               fshift = fshift + 6'd8;
            end
         end
         PH_CAPTION: begin
            if (b == CHAR_NEWLINE) begin
               cls = CL_CAPTION_END;
               if (next_pos == hdr_len) begin
                  start_pixels();
               end else begin
                  ph = PH_TAGS;
               end
            end else begin
               cls = CL_CAPTION;
            end
         end
         PH_TAGS: begin
            if (b == CHAR_NUL) begin
               cls = CL_TAG_END;
               if (next_pos == hdr_len) begin
                  start_pixels();
               end else if (next_pos > hdr_len) begin
                  err = ST_OVERRUN;
               end
            end else begin
               cls = CL_TAG;
            end
         end
         PH_PIXELS: begin
            cls = CL_PIXEL;
            pix_left = pix_left - 64'd1;
            if (pix_left == 0) begin
               ph = PH_DONE;
            end
         end
         default: cls = CL_TRAILING;
      endcase

      if (err != ST_BUSY) begin
         ph = PH_ERROR;
         err_latched = err;
      end

      // an error on the final byte wins over truncation
      if (ph == PH_ERROR) begin
         st = err_latched;
      end else if (ph == PH_DONE) begin
         st = ST_COMPLETE;
      end else begin
         st = fin ? ST_TRUNCATED : ST_BUSY;
      end

      res.byte_class = cls;
      res.byte_out = b;
      res.status = st;
      res.image_width = wid_val;
      res.image_height = hgt_val;

      byte_pos = next_pos;
      if (fin) begin
         case (st)
            ST_COMPLETE:  files_complete++;
            ST_TRUNCATED: files_cut++;
            default:      files_failed++;
         endcase
         clear_parser();
      end
      return res;
   endfunction

   // ---------------------------------------------------------------
   // file builder: assembles one file image, then queues it as beats
   // ---------------------------------------------------------------
   logic [7:0]     file_img[$];
   file_beat_type  file_beats[$];
   int unsigned    total_beats = 0;
   int unsigned    files_sent = 0;

   task automatic queue_file(input bit drain, input bit hold);
      file_beat_type fb;
      for (int i = 0; i < file_img.size(); i++) begin
         fb.data = file_img[i];
         fb.fin = (i == file_img.size() - 1);
         fb.wait_drain = drain && (i == 0);
         fb.hold_rsp = hold && (i == 0);
         file_beats = {file_beats, fb};
      end
      total_beats += file_img.size();
      files_sent++;
      file_img.delete();
   endtask

   task automatic put_field(input logic [63:0] value);
      for (int i = 0; i < FIELD_BYTES; i++) begin
         file_img = {file_img, value[8*i +: 8]};
      end
   endtask

   task automatic make_file(input file_kind_type kind, input bit drain, input bit hold);
      logic [63:0] wid;
      logic [63:0] hgt;
      logic [63:0] cont;
      logic [63:0] hdr;
      logic [7:0]  b;
      int          ntags;
      int          capl;
      int          capend;
      int          tagend1;
      int          npix;
      int          bad_at;
      int          cut;
      int          tag_len[3];

      if (kind == FK_NOISE) begin
         // raw junk: mostly a bad magic followed by trailing bytes
         repeat ($urandom_range(1, 12)) file_img = {file_img, 8'($urandom_range(0, 255))};
         queue_file(drain, hold);
         return;
      end

      wid = 64'($urandom_range(0, 3));
      hgt = 64'($urandom_range(0, 2));
      ntags = $urandom_range(0, 3);
      if (kind == FK_PLAIN) ntags = 0;
      if ((kind == FK_TAGGED || kind == FK_OVERRUN) && ntags == 0) ntags = 1;
      capl = $urandom_range(0, 6);
      foreach (tag_len[i]) tag_len[i] = $urandom_range(0, 4);

      capend = MAGIC_BYTES + 4 * FIELD_BYTES + capl + 1;
      tagend1 = capend + tag_len[0] + 1;
      hdr = 64'(capend);
      for (int i = 0; i < ntags; i++) hdr += 64'(tag_len[i] + 1);

      case (kind)
         FK_EMPTY:    hgt = '0;
         FK_ALL_ONES: begin
            // -1 fields are plain data: -1 * -1 * 3 = 3, -1 * 0 * 3 = 0
            wid = '1;
            hgt = $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
         end
         FK_MISMATCH: begin
            if ($urandom_range(0, 1)) begin
               wid = {$urandom, $urandom};
               hgt = {$urandom, $urandom};
            end
         end
         default: ;
      endcase
      cont = wid * hgt * 64'd3;

      case (kind)
         FK_MISMATCH: cont = cont + 64'($urandom_range(1, 1000));
         FK_OVERRUN: begin
            // header size short of the first tag end, but not the caption end
            hdr = 64'($urandom_range(0, tagend1 - 1));
            if (hdr == 64'(capend)) hdr = hdr - 64'd1;
         end
         FK_HUGE_HDR: begin
            case ($urandom_range(0, 2))
               0:       hdr = '1;
               1:       hdr = {1'b1, 31'($urandom), $urandom};
               default: hdr = {1'b0, 31'($urandom), $urandom};
            endcase
         end
         default: ;
      endcase

      for (int i = 0; i < MAGIC_BYTES; i++) file_img = {file_img, MAGIC_WORD[i]};
      put_field(hdr);
      put_field(cont);
      put_field(wid);
      put_field(hgt);
      repeat (capl) begin
         b = 8'($urandom_range(0, 255));
         if (b == CHAR_NEWLINE) b = 8'hFF;
         file_img = {file_img, b};
      end
      file_img = {file_img, CHAR_NEWLINE};
      for (int i = 0; i < ntags; i++) begin
         repeat (tag_len[i]) file_img = {file_img, 8'($urandom_range(1, 255))};
         file_img = {file_img, CHAR_NUL};
      end
      npix = (cont <= MAX_PIXELS) ? int'(cont) : $urandom_range(4, 12);
      repeat (npix) file_img = {file_img, 8'($urandom_range(0, 255))};
      repeat ($urandom_range(0, 3)) file_img = {file_img, 8'($urandom_range(0, 255))};

      case (kind)
         FK_TRUNC: begin
            cut = $urandom_range(1, file_img.size() - 1);
            while (file_img.size() > cut) void'(file_img.pop_back());
         end
         FK_BAD_MAGIC: begin
            bad_at = $urandom_range(0, MAGIC_BYTES - 1);
            file_img[bad_at] = file_img[bad_at] ^ 8'($urandom_range(1, 255));
            cut = bad_at + 1 + $urandom_range(0, 7);
            while (file_img.size() > cut) void'(file_img.pop_back());
         end
         default: ;
      endcase
      queue_file(drain, hold);
   endtask

   // ---------------------------------------------------------------
   // sender: bursts of beats with random gaps, fed from file_beats
   // ---------------------------------------------------------------
   result_type  predicted_beats[$];
   logic        req_fire = 1'b0;   // beat taken at the last rising edge
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned hold_token = 0;

   always @(negedge clock) begin
      file_beat_type fb;
      logic          next_valid;
      next_valid = req_valid;
      // a stalled beat stays put; otherwise pick the next one or idle
      if (!reset && !(req_valid && !req_fire)) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (file_beats.size() != 0 &&
                      !(file_beats[0].wait_drain && predicted_beats.size() != 0)) begin
            fb = file_beats.pop_front();
            req_data_byte <= fb.data;
            req_last_byte <= fb.fin;
            next_valid = 1'b1;
            if (fb.hold_rsp) hold_token <= hold_token + 1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               // now and then a long unbroken run, otherwise short bursts
               if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(40, 120);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = $urandom_range(1, 6);
               end
            end
         end
      end
      req_valid <= next_valid;
   end

   // ---------------------------------------------------------------
   // receiver: stall pattern of its own plus the long hold-off
   // ---------------------------------------------------------------
   rx_mode_type rx_mode = RX_OPEN;
   int unsigned rx_mode_left = 0;
   int unsigned rx_tick = 0;
   int unsigned hold_left = 0;
   int unsigned hold_seen = 0;

   always @(negedge clock) begin
      rx_tick++;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(16, 80);
         end
         rx_mode_left--;
         case (rx_mode)
            RX_OPEN:     rsp_stall <= 1'b0;
            RX_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 40);
            default:     rsp_stall <= (rx_tick % 3 == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // monitor: predict on each accepted input beat, check each result
   // ---------------------------------------------------------------
   int unsigned beats_taken = 0;
   int unsigned results_checked = 0;
   int unsigned mismatches = 0;

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         if (mismatches < MAX_REPORTS) begin
            $display("%0t: result %0d %s expected %0h actual %0h",
                     $time, results_checked, what, want, got);
         end
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire) begin
         predicted_beats = {predicted_beats, classify_byte(req_data_byte, req_last_byte)};
         beats_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_beats.size() == 0) begin
            if (mismatches < MAX_REPORTS) begin
               $display("%0t: result beat with nothing expected, expected none actual %0h/%0h/%0h",
                        $time, rsp_byte_class, rsp_byte_out, rsp_status);
            end
            mismatches++;
         end else begin
            want = predicted_beats.pop_front();
            check_field("class", 64'(want.byte_class), 64'(rsp_byte_class));
            check_field("byte", 64'(want.byte_out), 64'(rsp_byte_out));
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("width", want.image_width, rsp_image_width);
            check_field("height", want.image_height, rsp_image_height);
            results_checked++;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      file_kind_type kind;
      int unsigned   r;
      int unsigned   base;

      clear_parser();

      // directed: short files around the magic word
      // magic only, cut off before the first field
      file_img = '{MAGIC_WORD[0], MAGIC_WORD[1], MAGIC_WORD[2], MAGIC_WORD[3]};
      queue_file(1'b0, 1'b0);
      // bad first byte that is also the final byte: error beats truncation
      file_img = '{8'h00};
      queue_file(1'b0, 1'b0);
      // bad magic, then a trailing byte
      file_img = '{8'hFF, 8'h41};
      queue_file(1'b0, 1'b0);
      // wrong third byte
      file_img = '{MAGIC_WORD[0], MAGIC_WORD[1], 8'h00};
      queue_file(1'b0, 1'b0);
      // wrong fourth byte, flagged on that byte
      file_img = '{MAGIC_WORD[0], MAGIC_WORD[1], MAGIC_WORD[2], 8'h47};
      queue_file(1'b0, 1'b0);
      // cut off inside the header size field, with 0xFF data
      file_img = '{MAGIC_WORD[0], MAGIC_WORD[1], MAGIC_WORD[2], MAGIC_WORD[3],
                   8'hFF, 8'hFF, 8'hFF};
      queue_file(1'b0, 1'b0);

      // one file of every kind first, then a random mix, half of it good files;
      // the second file triggers the long hold-off, the fourth waits for a drain
      base = files_sent;
      for (int k = 0; k <= FK_NOISE; k++) begin
         make_file(file_kind_type'(k), (files_sent - base) == 3, (files_sent - base) == 1);
      end
      while (total_beats < TARGET_BEATS) begin
         r = $urandom_range(0, 99);
         if (r < 20)      kind = FK_TAGGED;
         else if (r < 32) kind = FK_PLAIN;
         else if (r < 42) kind = FK_EMPTY;
         else if (r < 50) kind = FK_ALL_ONES;
         else if (r < 62) kind = FK_TRUNC;
         else if (r < 70) kind = FK_MISMATCH;
         else if (r < 78) kind = FK_OVERRUN;
         else if (r < 84) kind = FK_HUGE_HDR;
         else if (r < 92) kind = FK_BAD_MAGIC;
         else             kind = FK_NOISE;
         make_file(kind, $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every beat taken and every result back
      while (beats_taken < total_beats || predicted_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d files: %0d complete, %0d with errors, %0d cut short",
               files_sent, files_complete, files_failed, files_cut);
      $display("%0d bytes sent, %0d result beats checked, %0d mismatches",
               beats_taken, results_checked, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #LIMIT_NS;
      $display("timeout with %0d results outstanding", predicted_beats.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
